/* rtl/core/mpst_pkg.sv */
// types, constants and pattern table for the memory pattern self test core
`timescale 1ns / 1ps

package mpst_pkg;

  localparam int unsigned AddrW        = 32;
  localparam int unsigned DataW        = 32;
  localparam int unsigned SizeW        = 26;
  localparam int unsigned WordW        = SizeW - 2;
  localparam int unsigned MemBytesLog2 = 25;
  // power of two, so the alignment check is a mask
  localparam int unsigned AlignBytes   = 32;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [SizeW-1:0]    ErrMax    = SizeW'(33554432);
  localparam logic [32:0]         MaxSize   = 33'd1 << MemBytesLog2;
  localparam logic [AddrW-1:0]    AlignMask = AddrW'(AlignBytes - 1);
  localparam logic [7:0]          AbortMask = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_SIZE_BYTES   = 2'd1,
    CFG_ABORT_ENABLE = 2'd2,
    CFG_UNUSED       = 2'd3
  } mpst_cfg_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } mpst_func_e;

  typedef struct packed {
    logic             func;
    logic [DataW-1:0] read_data;
    logic             abort;
  } mpst_in_t;

  typedef struct packed {
    logic             access_valid;
    logic             access_write;
    logic [AddrW-1:0] access_address;
    logic [DataW-1:0] write_data;
    logic             done_res;
    logic             passed;
    logic             aborted;
    logic [SizeW-1:0] error_count;
  } mpst_out_t;

  function automatic logic [DataW-1:0] pattern_word(input logic [1:0] idx);
    logic [DataW-1:0] w;
    case (idx)
      2'd0:    w = 32'h0000_0000;
      2'd1:    w = 32'hFFFF_FFFF;
      2'd2:    w = 32'hA5A5_A5A5;
      2'd3:    w = 32'h5A5A_5A5A;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/memory_pattern_self_test_core.sv */
// Memory built-in self test core: start checks the setup, then runs four fixed patterns,
// writing every word and reading every word back, at most one access command per item. Each
// item is handled combinationally: the sequencer state and the result update at the edge
// that accepts it, so a new item is taken every cycle while the input is not stalled. Results
// leave through an output register backed by one skid entry; the input stalls only when both
// hold an item. Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps

module memory_pattern_self_test_core import mpst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpst_in_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mpst_out_t          out_item_o
);

  logic [AddrW-1:0] base_q;
  logic [SizeW-1:0] size_q;
  logic             abort_en_q;

  logic             running_q, running_d;
  logic             read_phase_q, read_phase_d;
  logic [1:0]       pattern_q, pattern_d;
  logic [WordW-1:0] word_q, word_d;
  logic [SizeW-1:0] count_q, count_d;

  mpst_out_t        res;
  mpst_out_t        out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  logic             in_fire, out_fire;
  logic             emit_access, setup_bad;
  logic [WordW-1:0] words;
  logic [WordW:0]   word_inc;
  mpst_cfg_e        cfg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_sel     = mpst_cfg_e'(cfg_index_i);
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      size_q     <= '0;
      abort_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_sel)
        CFG_BASE_ADDRESS: base_q     <= cfg_data_i;
        CFG_SIZE_BYTES:   size_q     <= cfg_data_i[SizeW-1:0];
        CFG_ABORT_ENABLE: abort_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign words     = size_q[SizeW-1:2];
  assign word_inc  = {1'b0, word_q} + 1'b1;
  assign setup_bad = (size_q == '0) || (size_q[1:0] != 2'b00) ||
                     ({7'b0, size_q} > MaxSize) || ((base_q & AlignMask) != '0);

  always_comb begin
    running_d    = running_q;
    read_phase_d = read_phase_q;
    pattern_d    = pattern_q;
    word_d       = word_q;
    count_d      = count_q;
    emit_access  = 1'b0;
    res          = '0;
    if (in_item_i.func == FUNC_START) begin
      running_d    = 1'b0;
      read_phase_d = 1'b0;
      pattern_d    = '0;
      word_d       = '0;
      count_d      = '0;
      if (setup_bad) begin
        res.done_res = 1'b1;
      end else begin
        running_d   = 1'b1;
        emit_access = 1'b1;
      end
    end else if (running_q) begin
      if (read_phase_q && (in_item_i.read_data != pattern_word(pattern_q)) &&
          (count_q < ErrMax)) begin
        count_d = count_q + 1'b1;
      end
      if (((word_q[7:0] & AbortMask) == 8'h00) && abort_en_q && in_item_i.abort) begin
        running_d   = 1'b0;
        res.done_res = 1'b1;
        res.aborted  = 1'b1;
      end else if (word_inc < {1'b0, words}) begin
        word_d      = word_inc[WordW-1:0];
        emit_access = 1'b1;
      end else begin
        word_d = '0;
        if (!read_phase_q) begin
          read_phase_d = 1'b1;
          emit_access  = 1'b1;
        end else begin
          read_phase_d = 1'b0;
          if (pattern_q == 2'd3) begin
            running_d    = 1'b0;
            pattern_d    = '0;
            res.done_res = 1'b1;
            res.passed   = (count_d == '0);
          end else begin
            pattern_d   = pattern_q + 1'b1;
            emit_access = 1'b1;
          end
        end
      end
    end
    if (emit_access) begin
      res.access_valid   = 1'b1;
      res.access_write   = !read_phase_d;
      res.access_address = base_q + (AddrW'(word_d) << 2);
      res.write_data     = read_phase_d ? '0 : pattern_word(pattern_d);
    end
    res.error_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      read_phase_q <= 1'b0;
      pattern_q    <= '0;
      word_q       <= '0;
      count_q      <= '0;
    end else if (in_fire) begin
      running_q    <= running_d;
      read_phase_q <= read_phase_d;
      pattern_q    <= pattern_d;
      word_q       <= word_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= in_fire;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

endmodule

/* rtl/core/mpst_checker.sv */
// port checker for the memory pattern self test core and its bind
`timescale 1ns / 1ps

module mpst_checker import mpst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input mpst_out_t out_item_o
);

  // stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // an access command never comes with a finish status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.access_valid |-> !out_item_o.done_res)
    else $error("access issued together with done");

  // pass only on a clean finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.passed |->
      out_item_o.done_res && !out_item_o.aborted && out_item_o.error_count == '0)
    else $error("pass reported with errors or abort");

  // abort ends the test without a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.aborted |-> out_item_o.done_res && !out_item_o.passed)
    else $error("abort status inconsistent");

endmodule

bind memory_pattern_self_test_core mpst_checker u_mpst_checker (.*);
